FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the QOI encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds on every clock edge outside reset.
`define QOIE_ASSERT_ALW(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("qoie: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define QOIE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qoie: implication violated");

// Consequent holds in the cycle after the antecedent.
`define QOIE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qoie: next-cycle implication violated");

`endif

FILE: rtl/core/qoie_pkg.sv
// Types, opcodes and the index hash shared by the QOI encoder modules.
package qoie_pkg;

    localparam int MaxBytes = 14;
    localparam int CntW     = 4;

    typedef logic [7:0] t_byte;
    typedef t_byte [MaxBytes-1:0] t_bytes;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pixel;

    typedef struct packed {
        t_bytes          bytes;
        logic [CntW-1:0] count;
    } t_burst;

    localparam t_pixel PixReset = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hff};

    localparam t_byte OpIndex  = 8'h00;
    localparam t_byte OpDiff   = 8'h40;
    localparam t_byte OpLuma   = 8'h80;
    localparam t_byte OpRun    = 8'hc0;
    localparam t_byte OpRunMax = 8'hfd;
    localparam t_byte OpRgb    = 8'hfe;
    localparam t_byte OpRgba   = 8'hff;
    localparam t_byte EndLast  = 8'h01;

    localparam logic [5:0] RunLimit  = 6'd62;
    localparam logic [CntW-1:0] EndZeros = 4'd7;

    function automatic logic [5:0] slot_hash(t_pixel p);
        logic [12:0] s;
        s = 13'(p.r) * 13'd3 + 13'(p.g) * 13'd5 + 13'(p.b) * 13'd7 + 13'(p.a) * 13'd11;
        return s[5:0];
    endfunction

endpackage

FILE: rtl/core/qoie_serializer.sv
// Output serializer that sends a burst of encoded bytes one beat at a time.
module qoie_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  qoie_pkg::t_burst i_burst,
    output logic            o_free,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_code_byte,
    output logic            o_last_of_item
);
    import qoie_pkg::*;

    t_bytes          r_buf;
    logic [CntW-1:0] r_cnt;
    logic            take;

    assign take           = (r_cnt != '0) && !i_out_stall;
    assign o_free         = (r_cnt == '0) || ((r_cnt == CntW'(1)) && take);
    assign o_out_valid    = (r_cnt != '0);
    assign o_code_byte    = r_buf[0];
    assign o_last_of_item = (r_cnt == CntW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (take) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_burst.bytes;
        end else if (take) begin
            r_buf <= r_buf >> 8;
        end
    end

    `include "assert_macros.svh"

    `QOIE_ASSERT_ALW(a_cnt_bound, r_cnt <= CntW'(MaxBytes))
    `QOIE_ASSERT_IMP(a_load_when_free, i_load, o_free && i_burst.count != '0)
    `QOIE_ASSERT_NXT(a_drain_empty, take && r_cnt == CntW'(1) && !i_load, r_cnt == '0)

endmodule

FILE: rtl/core/qoi_image_encoder.sv
// Top level of the QOI payload encoder: pixel register, state, opcode choice, index memory.
// A pixel is registered in the input stage, then its bytes go into the serializer buffer.
// Throughput: one pixel per cycle while each pixel yields at most one byte and no output stall;
// a pixel with n bytes holds back the next until all n leave the single byte-wide output port.
// Reset clears the run count, the index valid flags and all handshakes, and sets the previous pixel
// to PixReset; the index memory is not swept, since an entry without its valid flag reads as zero.
module qoi_image_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_alpha,
    input  logic       i_final_pixel,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_code_byte,
    output logic       o_last_of_item
);
    import qoie_pkg::*;

    t_pixel r_mem [64];

    t_pixel      in_pix;
    logic [5:0]  in_slot;
    logic        in_acc;

    logic        r_s1_v;
    t_pixel      r_s1_pix;
    logic        r_s1_final;
    logic [5:0]  r_s1_slot;
    t_pixel      r_mem_q;
    logic        r_ent_ok;
    logic        r_fwd;
    t_pixel      r_fwd_pix;

    t_pixel      r_prev;
    logic [5:0]  r_run;
    logic [63:0] r_ent_vld;

    t_pixel      n_prev;
    logic [5:0]  n_run;
    t_pixel      entry;
    logic        mem_we;
    t_burst      burst;
    logic        s1_go;
    logic        ser_free;
    logic        ser_load;
    logic        fwd_now;
    logic        clr_now;

    logic signed [8:0] dr, dg, db;
    logic signed [9:0] lr, lb;
    logic signed [8:0] dr2, dg2, db2, dg32;
    logic signed [9:0] lr8, lb8;
    logic        small_diff;
    logic        luma_ok;
    logic [5:0]  run_tmp;
    logic [CntW-1:0] cnt;

    assign in_pix  = '{r: i_red, g: i_green, b: i_blue, a: i_alpha};
    assign in_slot = slot_hash(in_pix);

    assign entry = !r_ent_ok ? t_pixel'('0) : (r_fwd ? r_fwd_pix : r_mem_q);

    assign dr   = $signed({1'b0, r_s1_pix.r}) - $signed({1'b0, r_prev.r});
    assign dg   = $signed({1'b0, r_s1_pix.g}) - $signed({1'b0, r_prev.g});
    assign db   = $signed({1'b0, r_s1_pix.b}) - $signed({1'b0, r_prev.b});
    assign lr   = $signed({dr[8], dr}) - $signed({dg[8], dg});
    assign lb   = $signed({db[8], db}) - $signed({dg[8], dg});
    assign dr2  = dr + 9'sd2;
    assign dg2  = dg + 9'sd2;
    assign db2  = db + 9'sd2;
    assign dg32 = dg + 9'sd32;
    assign lr8  = lr + 10'sd8;
    assign lb8  = lb + 10'sd8;

    assign small_diff = (dr >= -9'sd2) && (dr <= 9'sd1) && (dg >= -9'sd2) && (dg <= 9'sd1)
                        && (db >= -9'sd2) && (db <= 9'sd1);
    assign luma_ok    = (dg >= -9'sd32) && (dg <= 9'sd31) && (lr >= -10'sd8) && (lr <= 10'sd7)
                        && (lb >= -10'sd8) && (lb <= 10'sd7);

    always_comb begin
        burst   = '0;
        cnt     = '0;
        mem_we  = 1'b0;
        n_prev  = r_prev;
        run_tmp = '0;
        if (r_s1_pix == r_prev) begin
            run_tmp = r_run + 6'd1;
            if (run_tmp == RunLimit) begin
                burst.bytes[cnt] = OpRunMax;
                cnt = cnt + CntW'(1);
                run_tmp = '0;
            end
        end else begin
            if (r_run != '0) begin
                burst.bytes[cnt] = OpRun | {2'b00, r_run - 6'd1};
                cnt = cnt + CntW'(1);
            end
            n_prev = r_s1_pix;
            if (entry == r_s1_pix) begin
                burst.bytes[cnt] = OpIndex | {2'b00, r_s1_slot};
                cnt = cnt + CntW'(1);
            end else begin
                mem_we = 1'b1;
                if (r_s1_pix.a != r_prev.a) begin
                    burst.bytes[cnt] = OpRgba;
                    burst.bytes[cnt + CntW'(1)] = r_s1_pix.r;
                    burst.bytes[cnt + CntW'(2)] = r_s1_pix.g;
                    burst.bytes[cnt + CntW'(3)] = r_s1_pix.b;
                    burst.bytes[cnt + CntW'(4)] = r_s1_pix.a;
                    cnt = cnt + CntW'(5);
                end else if (small_diff) begin
                    burst.bytes[cnt] = OpDiff | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
                    cnt = cnt + CntW'(1);
                end else if (luma_ok) begin
                    burst.bytes[cnt] = OpLuma | {2'b00, dg32[5:0]};
                    burst.bytes[cnt + CntW'(1)] = {lr8[3:0], lb8[3:0]};
                    cnt = cnt + CntW'(2);
                end else begin
                    burst.bytes[cnt] = OpRgb;
                    burst.bytes[cnt + CntW'(1)] = r_s1_pix.r;
                    burst.bytes[cnt + CntW'(2)] = r_s1_pix.g;
                    burst.bytes[cnt + CntW'(3)] = r_s1_pix.b;
                    cnt = cnt + CntW'(4);
                end
            end
        end
        n_run = run_tmp;
        if (r_s1_final) begin
            if (run_tmp != '0) begin
                burst.bytes[cnt] = OpRun | {2'b00, run_tmp - 6'd1};
                cnt = cnt + CntW'(1);
            end
            cnt = cnt + EndZeros;
            burst.bytes[cnt] = EndLast;
            cnt = cnt + CntW'(1);
            n_prev = PixReset;
            n_run  = '0;
        end
        burst.count = cnt;
    end

    assign s1_go      = r_s1_v && ((burst.count == '0) || ser_free);
    assign ser_load   = s1_go && (burst.count != '0);
    assign o_in_stall = r_s1_v && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign clr_now    = s1_go && r_s1_final;
    assign fwd_now    = s1_go && mem_we && (r_s1_slot == in_slot) && !r_s1_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_prev    <= PixReset;
            r_run     <= '0;
            r_ent_vld <= '0;
        end else begin
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go) begin
                r_prev <= n_prev;
                r_run  <= n_run;
                if (r_s1_final) begin
                    r_ent_vld <= '0;
                end else if (mem_we) begin
                    r_ent_vld[r_s1_slot] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix   <= in_pix;
            r_s1_final <= i_final_pixel;
            r_s1_slot  <= in_slot;
            r_ent_ok   <= !clr_now && (fwd_now || r_ent_vld[in_slot]);
            r_fwd      <= fwd_now;
            r_fwd_pix  <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && mem_we) begin
            r_mem[r_s1_slot] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_q <= r_mem[in_slot];
        end
    end

    qoie_serializer u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (ser_load),
        .i_burst        (burst),
        .o_free         (ser_free),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_code_byte    (o_code_byte),
        .o_last_of_item (o_last_of_item)
    );

    `include "assert_macros.svh"

    `QOIE_ASSERT_ALW(a_run_bound, r_run < RunLimit)
    `QOIE_ASSERT_NXT(a_final_clears, s1_go && r_s1_final,
                     r_run == '0 && r_prev == PixReset && r_ent_vld == '0)
    `QOIE_ASSERT_IMP(a_stall_only_on_bytes, o_in_stall, r_s1_v && burst.count != '0)

endmodule
